@@ sv/pfc_pkg.sv @@
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int SIDE      = 5;
    localparam int CELLS     = 25;
    localparam int LETTERS   = 26;
    localparam int CHAR_W    = 7;
    localparam int LETTER_W  = 5;
    localparam int POS_W     = 5;
    localparam int COORD_W   = 3;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
    localparam logic [CHAR_W-1:0]   ASCII_A  = 7'd65;

    localparam logic [2:0] CFG_ADDR_DECRYPT = 3'd0;

    typedef enum logic [2:0] {
        OP_KEY_START  = 3'd0,
        OP_KEY_LETTER = 3'd1,
        OP_KEY_END    = 3'd2,
        OP_TEXT       = 3'd3,
        OP_FLUSH      = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS_A,
        ST_POS_B,
        ST_CALC,
        ST_CELL_A,
        ST_CELL_B,
        ST_LOAD,
        ST_OUT0,
        ST_OUT1
    } state_t;

    typedef struct packed {
        logic                ok;
        logic [LETTER_W-1:0] idx;
    } letter_t;

    function automatic letter_t decode_letter(input logic [7:0] c);
        letter_t r;
        r.ok  = (c[7:6] == 2'b01) && (c[4:0] >= 5'd1) && (c[4:0] <= 5'd26);
        r.idx = c[4:0] - 5'd1;
        return r;
    endfunction

    function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] l);
        return (l == LETTER_J) ? LETTER_I : l;
    endfunction

    function automatic logic [COORD_W-1:0] row_of(input logic [POS_W-1:0] p);
        logic [COORD_W-1:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] row_base(input logic [COORD_W-1:0] r);
        return 5'({r, 2'b00}) + 5'(r);
    endfunction

    function automatic logic [COORD_W-1:0] col_of(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] d;
        d = p - row_base(row_of(p));
        return d[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] step5(input logic [COORD_W-1:0] c,
                                                 input logic dec);
        logic [COORD_W-1:0] r;
        if (dec) begin
            r = (c == 3'd0) ? 3'd4 : c - 3'd1;
        end else begin
            r = (c >= 3'd4) ? 3'd0 : c + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] letter_char(input logic [LETTER_W-1:0] l);
        logic [LETTER_W-1:0] m;
        m = (l > LAST_LETTER) ? l - 5'd26 : l;
        return ASCII_A + 7'(m);
    endfunction

endpackage

@@ sv/playfair_digraph_cipher.sv @@
`timescale 1ns / 1ps

// Playfair cipher over a 5x5 key square, one transaction at a time.
// The input channel (s_) carries an operation code and a raw byte: key start,
// key letter, key end, text letter or text end flush. The result channel (m_)
// carries the coded letters of a pair, two transactions with m_pair_last high
// on the second. The APB port holds decrypt_mode at address 0; the user must
// write it only while the block is idle; the block itself does not enforce it.
// A key start, a key letter, a lone text letter and an empty flush are done
// in the idle state. A key end walks the alphabet one letter per cycle.
// A coded pair walks two lookups through the position store and two through
// the square store, one read port each, then loads the result register and
// offers the first letter. s_ready is low for the whole of that work.
// When the receiver stalls, the result register holds its letter and the
// block waits; nothing is dropped. Reset clears the used letters, the fill
// count, the open pair and the mode; the square and the positions hold
// whatever they held until a key writes them.
module playfair_digraph_cipher
    import pfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_char_out,
    output logic        m_pair_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t              state_reg, state_next;
    logic [LETTERS-1:0]  used_reg, used_next;
    logic [POS_W-1:0]    fill_reg, fill_next;
    logic [LETTER_W-1:0] pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                decrypt_reg;
    logic [LETTER_W-1:0] k_reg, k_next;
    logic [LETTER_W-1:0] a_reg, a_next;
    logic [LETTER_W-1:0] b_reg, b_next;
    logic [POS_W-1:0]    pa_reg, pa_next;
    logic [POS_W-1:0]    cella_reg, cella_next;
    logic [POS_W-1:0]    cellb_reg, cellb_next;
    logic [LETTER_W-1:0] cha_reg, cha_next;
    logic [LETTER_W-1:0] chb_reg, chb_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;

    logic                wr_en;
    logic [LETTER_W-1:0] wr_letter;
    logic [POS_W-1:0]    pos_rd_addr, pos_rd_data;
    logic [POS_W-1:0]    sq_rd_addr, sq_rd_data;

    letter_t             in_letter;
    logic [LETTER_W-1:0] in_folded;
    logic [COORD_W-1:0]  ra, ca, rb, cb, ra2, ca2, rb2, cb2;

    pfc_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_square (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg),
        .wr_data (wr_letter),
        .rd_addr (sq_rd_addr),
        .rd_data (sq_rd_data)
    );

    pfc_ram #(.WIDTH(POS_W), .DEPTH(LETTERS)) u_position (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_letter),
        .wr_data (fill_reg),
        .rd_addr (pos_rd_addr),
        .rd_data (pos_rd_data)
    );

    assign in_letter = decode_letter(s_char_in);
    assign in_folded = fold_j(in_letter.idx);

    assign ra = row_of(pa_reg);
    assign ca = col_of(pa_reg);
    assign rb = row_of(pos_rd_data);
    assign cb = col_of(pos_rd_data);

    always_comb begin
        ra2 = ra;
        rb2 = rb;
        ca2 = cb;
        cb2 = ca;
        if (ra == rb) begin
            ca2 = step5(ca, decrypt_reg);
            cb2 = step5(cb, decrypt_reg);
        end else if (ca == cb) begin
            ca2 = ca;
            cb2 = cb;
            ra2 = step5(ra, decrypt_reg);
            rb2 = step5(rb, decrypt_reg);
        end
    end

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        fill_next       = fill_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        k_next          = k_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        pa_next         = pa_reg;
        cella_next      = cella_reg;
        cellb_next      = cellb_reg;
        cha_next        = cha_reg;
        chb_next        = chb_reg;
        m_valid_next    = m_valid_reg;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;
        wr_letter       = in_folded;
        pos_rd_addr     = a_reg;
        sq_rd_addr      = cella_reg;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_operation)
                        OP_KEY_START: begin
                            used_next = '0;
                            fill_next = '0;
                        end
                        OP_KEY_LETTER: begin
                            if (in_letter.ok && !used_reg[in_folded]
                                    && fill_reg < POS_W'(CELLS)) begin
                                wr_en                = 1'b1;
                                used_next[in_folded] = 1'b1;
                                fill_next            = fill_reg + 5'd1;
                            end
                        end
                        OP_KEY_END: begin
                            k_next     = '0;
                            state_next = ST_FILL;
                        end
                        OP_TEXT: begin
                            if (in_letter.ok) begin
                                if (!pend_valid_reg) begin
                                    pend_next       = in_letter.idx;
                                    pend_valid_next = 1'b1;
                                end else begin
                                    a_next     = fold_j(pend_reg);
                                    state_next = ST_POS_A;
                                    if (pend_reg == in_letter.idx) begin
                                        b_next = LETTER_X;
                                    end else begin
                                        b_next          = in_folded;
                                        pend_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        OP_FLUSH: begin
                            if (pend_valid_reg) begin
                                a_next          = fold_j(pend_reg);
                                b_next          = LETTER_X;
                                pend_valid_next = 1'b0;
                                state_next      = ST_POS_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                wr_letter = k_reg;
                if (k_reg != LETTER_J && !used_reg[k_reg] && fill_reg < POS_W'(CELLS)) begin
                    wr_en            = 1'b1;
                    used_next[k_reg] = 1'b1;
                    fill_next        = fill_reg + 5'd1;
                end
                k_next = k_reg + 5'd1;
                if (k_reg == LAST_LETTER) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POS_A: begin
                pos_rd_addr = a_reg;
                state_next  = ST_POS_B;
            end
            ST_POS_B: begin
                pos_rd_addr = b_reg;
                pa_next     = pos_rd_data;
                state_next  = ST_CALC;
            end
            ST_CALC: begin
                cella_next = row_base(ra2) + 5'(ca2);
                cellb_next = row_base(rb2) + 5'(cb2);
                state_next = ST_CELL_A;
            end
            ST_CELL_A: begin
                sq_rd_addr = cella_reg;
                state_next = ST_CELL_B;
            end
            ST_CELL_B: begin
                sq_rd_addr = cellb_reg;
                cha_next   = sq_rd_data;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                chb_next     = sq_rd_data;
                m_valid_next = 1'b1;
                m_char_next  = letter_char(cha_reg);
                m_last_next  = 1'b0;
                state_next   = ST_OUT0;
            end
            ST_OUT0: begin
                if (m_ready) begin
                    m_char_next = letter_char(chb_reg);
                    m_last_next = 1'b1;
                    state_next  = ST_OUT1;
                end
            end
            ST_OUT1: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        k_reg      <= k_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        pa_reg     <= pa_next;
        cella_reg  <= cella_next;
        cellb_reg  <= cellb_next;
        cha_reg    <= cha_next;
        chb_reg    <= chb_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr == CFG_ADDR_DECRYPT) begin
            decrypt_reg <= pwdata[0];
        end
    end

    assign prdata      = (paddr == CFG_ADDR_DECRYPT) ? {31'd0, decrypt_reg} : 32'd0;
    assign pready      = 1'b1;
    assign m_valid     = m_valid_reg;
    assign m_char_out  = m_char_reg;
    assign m_pair_last = m_last_reg;

endmodule

@@ sv/pfc_ram.sv @@
`timescale 1ns / 1ps

module pfc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/pfc_checker.sv @@
`timescale 1ns / 1ps

module pfc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_char_out,
    input logic       m_pair_last
);

    // The block never takes new work while a result is on offer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // The first letter of a pair is always followed by the second.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_pair_last) |=> (m_valid && m_pair_last))
        else $error("pair second letter missing");

    // A pair ends the result burst.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_pair_last) |=> !m_valid)
        else $error("extra result after a pair");

    // A stalled transaction keeps its letter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_char_out) && $stable(m_pair_last)))
        else $error("stalled result changed");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_char_out  (m_char_out),
    .m_pair_last (m_pair_last)
);

@@ tb/playfair_digraph_cipher_test.sv @@
`timescale 1ns / 1ps

module playfair_digraph_cipher_test;
    import pfc_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int MAX_WAIT = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_PRINTED = 100;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } coded_letter_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_operation;
    logic [7:0]  s_char_in;
    logic        m_valid;
    logic        m_ready;
    logic [6:0]  m_char_out;
    logic        m_pair_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [LETTER_W-1:0] key_cell [CELLS];
    logic [POS_W-1:0]    cell_of [LETTERS];
    logic [LETTERS-1:0]  placed;
    int                  cells_filled;
    logic [LETTER_W-1:0] open_letter;
    logic                open_pair;
    logic                mode_decrypt;

    coded_letter_t letters_due [$];
    coded_letter_t next_due;
    int            errors = 0;
    int            items_sent = 0;
    int            idle_cycles = 0;
    int            hold_off = 0;
    bit            full_rate = 1'b0;

    playfair_digraph_cipher dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_char_in   (s_char_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_pair_last (m_pair_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic int letter_of(input logic [7:0] c);
        int v;
        v = c;
        if (v >= "a" && v <= "z") begin
            v = v - 32;
        end
        return (v >= "A" && v <= "Z") ? v - "A" : -1;
    endfunction

    function automatic void place_in_square(input int l);
        if (cells_filled >= CELLS || placed[l]) begin
            return;
        end
        key_cell[cells_filled] = LETTER_W'(l);
        cell_of[l] = POS_W'(cells_filled);
        placed[l] = 1'b1;
        cells_filled++;
    endfunction

    function automatic void code_pair(input int a, input int b);
        int shift, pa, pb, ra, ca, rb, cb, tmp;
        shift = mode_decrypt ? 4 : 1;
        if (a == LETTER_J) begin
            a = LETTER_I;
        end
        if (b == LETTER_J) begin
            b = LETTER_I;
        end
        pa = cell_of[a];
        pb = cell_of[b];
        ra = pa / SIDE;
        ca = pa % SIDE;
        rb = pb / SIDE;
        cb = pb % SIDE;
        if (ra == rb) begin
            ca = (ca + shift) % SIDE;
            cb = (cb + shift) % SIDE;
        end else if (ca == cb) begin
            ra = (ra + shift) % SIDE;
            rb = (rb + shift) % SIDE;
        end else begin
            tmp = ca;
            ca = cb;
            cb = tmp;
        end
        letters_due.push_back(coded_letter_t'{ASCII_A + CHAR_W'(key_cell[ra * SIDE + ca]), 1'b0});
        letters_due.push_back(coded_letter_t'{ASCII_A + CHAR_W'(key_cell[rb * SIDE + cb]), 1'b1});
    endfunction

    function automatic void predict_item(input logic [2:0] op, input logic [7:0] ch);
        int l, k;
        l = letter_of(ch);
        case (op)
            OP_KEY_START: begin
                placed = '0;
                cells_filled = 0;
            end
            OP_KEY_LETTER: begin
                if (l >= 0) begin
                    place_in_square((l == LETTER_J) ? int'(LETTER_I) : l);
                end
            end
            OP_KEY_END: begin
                for (k = 0; k < LETTERS; k++) begin
                    if (k != LETTER_J) begin
                        place_in_square(k);
                    end
                end
            end
            OP_TEXT: begin
                if (l >= 0) begin
                    if (!open_pair) begin
                        open_letter = LETTER_W'(l);
                        open_pair = 1'b1;
                    end else if (open_letter == l) begin
                        code_pair(open_letter, LETTER_X);
                    end else begin
                        open_pair = 1'b0;
                        code_pair(open_letter, l);
                    end
                end
            end
            OP_FLUSH: begin
                if (open_pair) begin
                    open_pair = 1'b0;
                    code_pair(open_letter, LETTER_X);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'("A") + 8'($urandom_range(0, LETTERS - 1));
        if ($urandom_range(0, 1) == 1) begin
            c = c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] random_junk();
        logic [7:0] c;
        c = 8'($urandom);
        while (letter_of(c) >= 0) begin
            c = 8'($urandom);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    task automatic send_item(input logic [2:0] op, input logic [7:0] ch);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_char_in <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_item(op, ch);
        if (op == OP_KEY_START || op == OP_KEY_END || op == OP_FLUSH ||
            ((op == OP_KEY_LETTER || op == OP_TEXT) && letter_of(ch) >= 0)) begin
            items_sent++;
        end
    endtask

    task automatic send_string(input logic [2:0] op, input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_item(op, s[i]);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (letters_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic decrypt);
        settle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_DECRYPT;
        pwdata <= 32'(decrypt);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mode_decrypt = decrypt;
    endtask

    task automatic test_key_load();
        write_mode(1'b0);
        send_item(OP_KEY_START, 8'h00);
        send_string(OP_KEY_LETTER, "KeyJ@{");
        send_item(OP_KEY_LETTER, 8'hC1);
        send_item(OP_KEY_LETTER, "k");
        send_item(OP_KEY_END, 8'hFF);
    endtask

    task automatic test_text_rules();
        int k;
        send_string(OP_TEXT, "jilLqZ^");
        send_item(OP_TEXT, 8'h00);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_FLUSH, 8'hFF);
        for (k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++) begin
            send_item(3'(k), 8'hFF);
        end
    endtask

    task automatic test_full_square();
        send_item(OP_KEY_LETTER, "A");
        send_item(OP_KEY_END, 8'h00);
        send_string(OP_TEXT, "AB");
    endtask

    task automatic test_partial_rekey();
        send_item(OP_KEY_START, 8'h00);
        send_string(OP_KEY_LETTER, "zY");
        send_string(OP_TEXT, "Ab");
        send_item(OP_KEY_END, 8'h00);
    endtask

    task automatic test_backpressure();
        int i;
        write_mode(1'b0);
        hold_off = HOLD_CYCLES;
        for (i = 0; i < 40; i++) begin
            send_item(OP_TEXT, random_letter());
        end
        settle();
    endtask

    task automatic test_random_traffic(input logic decrypt, input int count);
        int stop, pick, n;
        logic [7:0] c;
        write_mode(decrypt);
        stop = items_sent + count;
        while (items_sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_item(OP_KEY_START, 8'($urandom));
                n = $urandom_range(0, 30);
                repeat (n) begin
                    send_item(OP_KEY_LETTER,
                              ($urandom_range(0, 9) == 0) ? random_junk() : random_letter());
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_item(OP_KEY_END, 8'($urandom));
                end
            end else if (pick < 85) begin
                n = $urandom_range(1, 16);
                c = random_letter();
                repeat (n) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 4) begin
                        send_item(OP_TEXT, c);
                    end else if (pick < 6) begin
                        send_item(OP_TEXT, random_junk());
                    end else begin
                        c = random_letter();
                        send_item(OP_TEXT, c);
                    end
                end
                if ($urandom_range(0, 4) == 0) begin
                    send_item(OP_FLUSH, 8'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(3'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end
            stall = full_rate ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (letters_due.size() == 0) begin
                report_mismatch("unexpected letter", m_char_out, 0);
            end else begin
                next_due = letters_due.pop_front();
                if (m_char_out != next_due.ch) begin
                    report_mismatch("char_out", m_char_out, next_due.ch);
                end
                if (m_pair_last != next_due.last) begin
                    report_mismatch("pair_last", m_pair_last, next_due.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("playfair_digraph_cipher_test NOT OK");
            $finish;
        end
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_operation <= OP_KEY_START;
        s_char_in <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= CFG_ADDR_DECRYPT;
        pwdata <= 32'd0;
        placed = '0;
        cells_filled = 0;
        open_letter = '0;
        open_pair = 1'b0;
        mode_decrypt = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_key_load();
        test_text_rules();
        test_full_square();
        test_partial_rekey();
        test_random_traffic(1'b1, 150);
        test_random_traffic(1'b0, 150);
        full_rate = 1'b1;
        test_random_traffic(1'b1, 120);
        full_rate = 1'b0;
        test_backpressure();
        test_random_traffic(1'b0, 150);

        settle();
        if (errors == 0) begin
            $display("playfair_digraph_cipher_test OK");
        end else begin
            $display("playfair_digraph_cipher_test NOT OK");
        end
        $finish;
    end

endmodule

@@ playfair_digraph_cipher.f @@
sv/pfc_pkg.sv
sv/pfc_ram.sv
sv/playfair_digraph_cipher.sv
sv/pfc_checker.sv
tb/playfair_digraph_cipher_test.sv
